@@ hw/rtl/fbpa_pkg.sv @@
// Shared types and constants of the fixed block pool allocator.
// Holds widths, opcodes, status codes, register indexes and the divider request and response.
// Depends on nothing; the top level and the divider import it, fbpa_ram does not.
package fbpa_pkg;

    localparam int DATA_W             = 32;
    localparam int STATUS_W           = 3;
    localparam int OPCODE_W           = 2;
    localparam int CFG_INDEX_W        = 2;
    localparam int DEFAULT_MAX_BLOCKS = 1024;
    localparam int POINTER_BYTES      = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_POOL_INVALID = 3'd1,
        ST_TOO_LARGE    = 3'd2,
        ST_ALIGN_LARGE  = 3'd3,
        ST_EXHAUSTED    = 3'd4,
        ST_NOT_BLOCK    = 3'd5,
        ST_ALREADY_FREE = 3'd6
    } status_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_BASE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_BYTES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_REQUEST = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_ALIGN    = 2'd3;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    // Answer of the shared divider; quotient and remainder are valid while done is high.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

@@ hw/rtl/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator: control sequencer, pool registers, free stack.
// Depends on fbpa_pkg, fbpa_ram (free stack and free bitmap) and fbpa_div (shared divider).
//
// Usage. A request is taken at a rising edge where start is high and busy is low; opcode picks
// allocate, free or rebuild, the other fields are its operands. Every request gives exactly one
// result, shown on status, result_address and free_blocks for the single cycle in which done is
// high. The receiver cannot stall: the result is gone after that cycle. busy drops in the done
// cycle, so a new request may be issued there.
// Steps of each request, from the accepting edge to the edge that raises done:
//   - a rejected allocate or free, or the unused opcode: the decode alone,
//   - a rebuild with an invalid setup: the decode, then the setup check,
//   - a successful allocate: the decode, stack read, address multiply, add,
//   - a free that passes the range check: the 32-step shared divider, a bitmap read and a
//     check; the divider alone when the address is off a block boundary or past the last block,
//   - a valid rebuild: the setup check, the shared divider, then the fill, one stack and bitmap
//     entry written per cycle.
// One request is in flight at a time, so reads and writes of the two memories never overlap.
// Configuration writes through cfg_write, cfg_index and cfg_data take effect at once and are
// used at the next rebuild; write them only while the block is idle.
// Reset clears the pool: it is invalid and empty until the first valid rebuild. Neither memory
// needs a clearing pass: a rebuild writes every stack entry and bitmap bit that can be read.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS,
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [fbpa_pkg::OPCODE_W-1:0]       opcode,
    input  logic [fbpa_pkg::DATA_W-1:0]         request_bytes,
    input  logic [fbpa_pkg::DATA_W-1:0]         request_alignment,
    input  logic [fbpa_pkg::DATA_W-1:0]         block_address,
    output logic [fbpa_pkg::STATUS_W-1:0]       status,
    output logic [fbpa_pkg::DATA_W-1:0]         result_address,
    output logic [CNT_W-1:0]                    free_blocks,
    input  logic                                cfg_write,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::DATA_W-1:0]         cfg_data
);
    import fbpa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REB_CHECK,
        S_DIV,
        S_FILL,
        S_FREE_RD,
        S_FREE_CHK,
        S_ALLOC_RD,
        S_ALLOC_OUT
    } state_t;

    // Rounds v up to a multiple of the power of two a; one extra bit catches overflow.
    function automatic logic [DATA_W:0] round_up(input logic [DATA_W-1:0] v,
                                                 input logic [DATA_W-1:0] a);
        logic [DATA_W:0] m;
        m = {1'b0, a - 1'b1};
        return ({1'b0, v} + m) & ~m;
    endfunction

    state_t              state_reg;
    logic                busy_reg;
    logic                done_reg;
    status_t             status_reg;
    logic [DATA_W-1:0]   result_reg;

    // Configuration registers.
    logic [DATA_W-1:0]   base_reg;
    logic [DATA_W-1:0]   bytes_reg;
    logic [DATA_W-1:0]   blkreq_reg;
    logic [DATA_W-1:0]   palign_reg;

    // Pool state.
    logic [DATA_W-1:0]   pool_start_reg;
    logic [DATA_W-1:0]   pool_bytes_reg;
    logic [DATA_W-1:0]   block_bytes_reg;
    logic [CNT_W-1:0]    block_total_reg;
    logic [CNT_W-1:0]    depth_reg;
    logic [DATA_W-1:0]   pool_align_reg;

    // Captured request and working values.
    logic [OPCODE_W-1:0] op_reg;
    logic [DATA_W-1:0]   req_bytes_reg;
    logic [DATA_W-1:0]   req_align_reg;
    logic [DATA_W-1:0]   addr_reg;
    logic [DATA_W:0]     bs_reg;
    logic [DATA_W:0]     aligned_reg;
    logic                reb_bad_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W+DATA_W-1:0] mul_reg;
    logic                div_start_reg;
    logic [DATA_W-1:0]   div_dividend_reg;
    logic [DATA_W-1:0]   div_divisor_reg;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // Memory ports.
    logic                stk_we;
    logic [IDX_W-1:0]    stk_waddr;
    logic [IDX_W-1:0]    stk_wdata;
    logic [IDX_W-1:0]    stk_raddr;
    logic [IDX_W-1:0]    stk_rdata;
    logic                mark_we;
    logic [IDX_W-1:0]    mark_waddr;
    logic [0:0]          mark_wdata;
    logic [IDX_W-1:0]    mark_raddr;
    logic [0:0]          mark_rdata;

    // Rebuild arithmetic on the configuration registers.
    logic [DATA_W-1:0]   amask;
    logic                align_bad;
    logic [DATA_W:0]     bs_req;
    logic [DATA_W:0]     bs_min;
    logic [DATA_W:0]     aligned_base;
    logic [DATA_W-1:0]   lead;
    logic [DATA_W-1:0]   cap;
    logic [DATA_W-1:0]   free_off;
    logic [CNT_W-1:0]    depth_dec;
    logic [CNT_W-1:0]    count_cap;
    logic                push_ok;

    always_comb
    begin
        amask        = palign_reg - 1'b1;
        align_bad    = (palign_reg == '0) || ((palign_reg & amask) != '0);
        bs_req       = round_up(blkreq_reg, palign_reg);
        bs_min       = round_up(DATA_W'(POINTER_BYTES), palign_reg);
        aligned_base = round_up(base_reg, palign_reg);
        lead         = aligned_reg[DATA_W-1:0] - base_reg;
        cap          = bytes_reg - lead;
        free_off     = addr_reg - pool_start_reg;
        depth_dec    = depth_reg - 1'b1;
        if (div_rsp.quotient > DATA_W'(MAX_BLOCKS))
        begin
            count_cap = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            count_cap = div_rsp.quotient[CNT_W-1:0];
        end
        push_ok = (mark_rdata == 1'b0) && (depth_reg < CNT_W'(MAX_BLOCKS));
    end

    // Memory control: the stack is filled and pushed, the bitmap set on fill and push and
    // cleared on pop.
    always_comb
    begin
        stk_we     = 1'b0;
        stk_waddr  = fill_reg[IDX_W-1:0];
        stk_wdata  = fill_reg[IDX_W-1:0];
        stk_raddr  = depth_dec[IDX_W-1:0];
        mark_we    = 1'b0;
        mark_waddr = fill_reg[IDX_W-1:0];
        mark_wdata = 1'b1;
        mark_raddr = k_reg;
        unique case (state_reg)
            S_FILL:
            begin
                if (fill_reg != block_total_reg)
                begin
                    stk_we  = 1'b1;
                    mark_we = 1'b1;
                end
            end
            S_FREE_CHK:
            begin
                if (push_ok)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[IDX_W-1:0];
                    stk_wdata  = k_reg;
                    mark_we    = 1'b1;
                    mark_waddr = k_reg;
                end
            end
            S_ALLOC_RD:
            begin
                mark_we    = 1'b1;
                mark_waddr = stk_rdata;
                mark_wdata = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            bytes_reg  <= '0;
            blkreq_reg <= '0;
            palign_reg <= DATA_W'(8);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BUFFER_BASE:   base_reg   <= cfg_data;
                CFG_BUFFER_BYTES:  bytes_reg  <= cfg_data;
                CFG_BLOCK_REQUEST: blkreq_reg <= cfg_data;
                CFG_POOL_ALIGN:    palign_reg <= cfg_data;
                default:           base_reg   <= base_reg;
            endcase
        end
    end

    // Request sequencer, pool state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            status_reg       <= ST_OK;
            result_reg       <= '0;
            pool_start_reg   <= '0;
            pool_bytes_reg   <= '0;
            block_bytes_reg  <= '0;
            block_total_reg  <= '0;
            depth_reg        <= '0;
            pool_align_reg   <= DATA_W'(8);
            op_reg           <= '0;
            req_bytes_reg    <= '0;
            req_align_reg    <= '0;
            addr_reg         <= '0;
            bs_reg           <= '0;
            aligned_reg      <= '0;
            reb_bad_reg      <= 1'b0;
            fill_reg         <= '0;
            k_reg            <= '0;
            mul_reg          <= '0;
            div_start_reg    <= 1'b0;
            div_dividend_reg <= '0;
            div_divisor_reg  <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg        <= opcode;
                        req_bytes_reg <= request_bytes;
                        req_align_reg <= request_alignment;
                        addr_reg      <= block_address;
                        busy_reg      <= 1'b1;
                        state_reg     <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    result_reg <= '0;
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            if (req_align_reg > pool_align_reg)
                            begin
                                status_reg <= ST_ALIGN_LARGE;
                                done_reg   <= 1'b1;
                                busy_reg   <= 1'b0;
                                state_reg  <= S_IDLE;
                            end
                            else if (block_bytes_reg == '0)
                            begin
                                status_reg <= ST_POOL_INVALID;
                                done_reg   <= 1'b1;
                                busy_reg   <= 1'b0;
                                state_reg  <= S_IDLE;
                            end
                            else if (req_bytes_reg > block_bytes_reg)
                            begin
                                status_reg <= ST_TOO_LARGE;
                                done_reg   <= 1'b1;
                                busy_reg   <= 1'b0;
                                state_reg  <= S_IDLE;
                            end
                            else if (depth_reg == '0)
                            begin
                                status_reg <= ST_EXHAUSTED;
                                done_reg   <= 1'b1;
                                busy_reg   <= 1'b0;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                // The stack read of the top entry was issued in this cycle.
                                depth_reg <= depth_dec;
                                state_reg <= S_ALLOC_RD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (addr_reg == '0)
                            begin
                                status_reg <= ST_NOT_BLOCK;
                                done_reg   <= 1'b1;
                                busy_reg   <= 1'b0;
                                state_reg  <= S_IDLE;
                            end
                            else if (block_bytes_reg == '0)
                            begin
                                status_reg <= ST_POOL_INVALID;
                                done_reg   <= 1'b1;
                                busy_reg   <= 1'b0;
                                state_reg  <= S_IDLE;
                            end
                            else if ((addr_reg < pool_start_reg) ||
                                     (free_off >= pool_bytes_reg))
                            begin
                                status_reg <= ST_NOT_BLOCK;
                                done_reg   <= 1'b1;
                                busy_reg   <= 1'b0;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                div_start_reg    <= 1'b1;
                                div_dividend_reg <= free_off;
                                div_divisor_reg  <= block_bytes_reg;
                                state_reg        <= S_DIV;
                            end
                        end
                        OP_REBUILD:
                        begin
                            // The old pool is dropped before the new one is checked.
                            pool_align_reg  <= palign_reg;
                            pool_start_reg  <= '0;
                            pool_bytes_reg  <= '0;
                            block_bytes_reg <= '0;
                            block_total_reg <= '0;
                            depth_reg       <= '0;
                            reb_bad_reg     <= (base_reg == '0) || (bytes_reg == '0) ||
                                               (blkreq_reg == '0) || align_bad;
                            bs_reg          <= (bs_req < bs_min) ? bs_min : bs_req;
                            aligned_reg     <= aligned_base;
                            state_reg       <= S_REB_CHECK;
                        end
                        default:
                        begin
                            status_reg <= ST_OK;
                            done_reg   <= 1'b1;
                            busy_reg   <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    endcase
                end
                S_REB_CHECK:
                begin
                    if (reb_bad_reg || bs_reg[DATA_W] || aligned_reg[DATA_W] ||
                        (lead >= bytes_reg))
                    begin
                        status_reg <= ST_POOL_INVALID;
                        done_reg   <= 1'b1;
                        busy_reg   <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        pool_start_reg   <= aligned_reg[DATA_W-1:0];
                        pool_bytes_reg   <= cap;
                        block_bytes_reg  <= bs_reg[DATA_W-1:0];
                        div_start_reg    <= 1'b1;
                        div_dividend_reg <= cap;
                        div_divisor_reg  <= bs_reg[DATA_W-1:0];
                        state_reg        <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (op_reg == OP_REBUILD)
                        begin
                            block_total_reg <= count_cap;
                            fill_reg        <= '0;
                            state_reg       <= S_FILL;
                        end
                        else if ((div_rsp.remainder != '0) ||
                                 (div_rsp.quotient >= DATA_W'(block_total_reg)))
                        begin
                            status_reg <= ST_NOT_BLOCK;
                            done_reg   <= 1'b1;
                            busy_reg   <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= div_rsp.quotient[IDX_W-1:0];
                            state_reg <= S_FREE_RD;
                        end
                    end
                end
                S_FILL:
                begin
                    // Block i goes to stack slot i, so the highest block sits on top.
                    if (fill_reg == block_total_reg)
                    begin
                        depth_reg  <= block_total_reg;
                        status_reg <= ST_OK;
                        done_reg   <= 1'b1;
                        busy_reg   <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                S_FREE_RD:
                begin
                    state_reg <= S_FREE_CHK;
                end
                S_FREE_CHK:
                begin
                    if (mark_rdata == 1'b1)
                    begin
                        status_reg <= ST_ALREADY_FREE;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        if (push_ok)
                        begin
                            depth_reg <= depth_reg + 1'b1;
                        end
                    end
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_ALLOC_RD:
                begin
                    mul_reg   <= {{DATA_W{1'b0}}, stk_rdata} *
                                 {{IDX_W{1'b0}}, block_bytes_reg};
                    state_reg <= S_ALLOC_OUT;
                end
                S_ALLOC_OUT:
                begin
                    result_reg <= pool_start_reg + mul_reg[DATA_W-1:0];
                    status_reg <= ST_OK;
                    done_reg   <= 1'b1;
                    busy_reg   <= 1'b0;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dividend_reg;
    assign div_req.divisor  = div_divisor_reg;

    fbpa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Free stack: slot i holds the index of a free block.
    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Free bitmap: one bit per block, set while the block sits on the stack.
    fbpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign result_address = result_reg;
    assign free_blocks    = depth_reg;

    // The stack never holds more blocks than the pool has.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= block_total_reg)
        else $error("free stack deeper than the pool");

    // An invalid pool is always empty.
    a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (block_bytes_reg == '0) |-> (depth_reg == '0))
        else $error("invalid pool reports free blocks");

    // A result ends the request: the block is free to take the next one.
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && (state_reg == S_IDLE)))
        else $error("result shown while a request is still in work");

    // An accepted request keeps the block busy until its result.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (busy_reg && !done_reg))
        else $error("accepted request did not hold busy");

endmodule

@@ hw/rtl/fbpa_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the free stack and the free bitmap of the allocator; no package needed.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fbpa_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by rebuild and free.
// Depends on fbpa_pkg for the data width and the request and response structs.
module fbpa_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fbpa_pkg::div_req_t req,
    output fbpa_pkg::div_rsp_t rsp
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              active_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dsr_reg;

    logic [DATA_W:0]   partial;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] rem_next;
    logic              bit_next;

    always_comb
    begin
        partial = {rem_reg, quo_reg[DATA_W-1]};
        trial   = partial - {1'b0, dsr_reg};
        if (!trial[DATA_W])
        begin
            rem_next = trial[DATA_W-1:0];
            bit_next = 1'b1;
        end
        else
        begin
            rem_next = partial[DATA_W-1:0];
            bit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], bit_next};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
